### rtl/vrcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrcp_pkg: shared types and constants for the ring contour point block
// Item structs, the ring coordinate tables and the per-cell slot bundle
// passed from the pipeline to the point emitter.
// ----------------------------------------------------------------------------
package vrcp_pkg;

    localparam int TYPE_BITS = 8;
    localparam int FIELD_BITS = 8;
    localparam int CMP_BITS = (TYPE_BITS < FIELD_BITS) ? TYPE_BITS : FIELD_BITS;
    localparam int RING = 8;

    localparam logic [15:0] COORD_NEG  = 16'd4915;
    localparam logic [15:0] COORD_ZERO = 16'd32768;
    localparam logic [15:0] COORD_POS  = 16'd60621;

    typedef struct packed {
        logic [FIELD_BITS-1:0] center_type;
        logic [FIELD_BITS-1:0] ring_top_left;
        logic [FIELD_BITS-1:0] ring_top;
        logic [FIELD_BITS-1:0] ring_top_right;
        logic [FIELD_BITS-1:0] ring_right;
        logic [FIELD_BITS-1:0] ring_bottom_right;
        logic [FIELD_BITS-1:0] ring_bottom;
        logic [FIELD_BITS-1:0] ring_bottom_left;
        logic [FIELD_BITS-1:0] ring_left;
    } t_in;

    typedef struct packed {
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic [2:0]  ring_index;
        logic [1:0]  line_number;
        logic        last_in_line;
        logic        last_of_cell;
    } t_out;

    // points of one cell in emit order: slot j is rotated ring position j
    typedef struct packed {
        logic [RING-1:0]       mask;
        logic [RING-1:0][2:0]  ridx;
        logic [RING-1:0][1:0]  lab;
        logic [RING-1:0]       lst;
        logic                  rep;
        logic [2:0]            rep_idx;
    } t_cell;

    function automatic logic [15:0] coord_x(input logic [2:0] idx);
        logic [15:0] v;
        case (idx)
            3'd0, 3'd6, 3'd7: v = COORD_NEG;
            3'd1, 3'd5:       v = COORD_ZERO;
            default:          v = COORD_POS;
        endcase
        return v;
    endfunction

    function automatic logic [15:0] coord_y(input logic [2:0] idx);
        logic [15:0] v;
        case (idx)
            3'd0, 3'd1, 3'd2: v = COORD_NEG;
            3'd3, 3'd7:       v = COORD_ZERO;
            default:          v = COORD_POS;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/voxel_ring_contour_points.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_ring_contour_points: border control points of one grid cell
// A cell passes stage 1, stage 2, stage 3, the emitter's slot register and
// its output register; the emitter sends one point per cycle and takes a new
// cell once at most one point is left; busy holds the pipeline meanwhile.
// Results cannot be stalled; each point is shown for one cycle.
// Synchronous active-low reset clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module voxel_ring_contour_points
    import vrcp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_in  i_item,
    output logic      o_strobe,
    output t_out      o_result
);

    // stage 1: differ flags
    logic            r_v1;
    logic [RING-1:0] r_diff;
    logic [RING-1:0] n_diff;

    // stage 2: ring walk
    logic                 r_v2;
    logic [RING-1:0]      r_pt;
    logic [RING-1:0][1:0] r_ln;
    logic [2:0]           r_nseg;
    logic [2:0]           r_lstart;
    logic                 r_wrap;
    logic [RING-1:0]      n_pt;
    logic [RING-1:0][1:0] n_ln;
    logic [2:0]           n_nseg;
    logic [2:0]           n_lstart;

    // stage 3: rotated slots
    logic  r_v3;
    t_cell r_cell;
    t_cell n_cell;

    logic ser_ready;
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic accept;

    assign s3_ready = !r_v3 || ser_ready;
    assign s2_ready = !r_v2 || s3_ready;
    assign s1_ready = !r_v1 || s2_ready;
    assign busy     = !s1_ready;
    assign accept   = start && s1_ready;

    always_comb begin
        logic [CMP_BITS-1:0] c;
        c = i_item.center_type[CMP_BITS-1:0];
        n_diff[0] = i_item.ring_top_left[CMP_BITS-1:0]     != c;
        n_diff[1] = i_item.ring_top[CMP_BITS-1:0]          != c;
        n_diff[2] = i_item.ring_top_right[CMP_BITS-1:0]    != c;
        n_diff[3] = i_item.ring_right[CMP_BITS-1:0]        != c;
        n_diff[4] = i_item.ring_bottom_right[CMP_BITS-1:0] != c;
        n_diff[5] = i_item.ring_bottom[CMP_BITS-1:0]       != c;
        n_diff[6] = i_item.ring_bottom_left[CMP_BITS-1:0]  != c;
        n_diff[7] = i_item.ring_left[CMP_BITS-1:0]         != c;
    end

    always_comb begin
        logic            open;
        logic            keep;
        logic [RING-1:0] dn;
        dn       = {r_diff[0], r_diff[RING-1:1]};
        open     = 1'b0;
        n_pt     = '0;
        n_ln     = '0;
        n_nseg   = 3'd0;
        n_lstart = 3'd0;
        for (int i = 0; i < RING; i++) begin
            keep = ((i % 2) == 0) || !dn[i];
            if (open) begin
                if (r_diff[i]) begin
                    if (keep) begin
                        n_pt[i] = 1'b1;
                        n_ln[i] = 2'(n_nseg - 3'd1);
                    end
                end else if (keep) begin
                    open = 1'b0;
                end
            end else if (r_diff[i] && dn[i]) begin
                n_pt[i]  = 1'b1;
                n_ln[i]  = 2'(n_nseg);
                n_lstart = 3'(i);
                n_nseg   = n_nseg + 3'd1;
                open     = 1'b1;
            end
        end
    end

    always_comb begin
        logic       join_l;
        logic       closed;
        logic [2:0] s;
        logic [2:0] p;
        logic       has_next;
        logic [1:0] nxt_lab;
        join_l   = r_wrap && (r_nseg > 3'd1);
        closed   = r_wrap && (r_nseg == 3'd1);
        s        = join_l ? r_lstart : 3'd0;
        for (int j = 0; j < RING; j++) begin
            p = s + 3'(j);
            n_cell.mask[j] = r_pt[p];
            n_cell.ridx[j] = p;
            n_cell.lab[j]  = (join_l && ({1'b0, r_ln[p]} == r_nseg - 3'd1)) ? 2'd0 : r_ln[p];
        end
        has_next = 1'b0;
        nxt_lab  = 2'd0;
        for (int j = RING - 1; j >= 0; j--) begin
            n_cell.lst[j] = n_cell.mask[j]
                && (has_next ? (n_cell.lab[j] != nxt_lab) : !closed);
            if (n_cell.mask[j]) begin
                has_next = 1'b1;
                nxt_lab  = n_cell.lab[j];
            end
        end
        n_cell.rep     = closed;
        n_cell.rep_idx = r_lstart;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_v1 <= accept;
            end
            if (s2_ready) begin
                r_v2 <= r_v1;
            end
            if (s3_ready) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_diff <= n_diff;
        end
        if (s2_ready && r_v1) begin
            r_pt     <= n_pt;
            r_ln     <= n_ln;
            r_nseg   <= n_nseg;
            r_lstart <= n_lstart;
            r_wrap   <= r_diff[0] && r_diff[RING-1];
        end
        if (s3_ready && r_v2) begin
            r_cell <= n_cell;
        end
    end

    vrcp_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_v3 && ser_ready),
        .i_cell   (r_cell),
        .o_ready  (ser_ready),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_strobe)
        else $error("strobe after reset");
    a_cell_end_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_of_cell |-> o_result.last_in_line)
        else $error("cell ended inside a line");
    a_coord_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.point_x == coord_x(o_result.ring_index))
                  && (o_result.point_y == coord_y(o_result.ring_index)))
        else $error("point coordinate does not match ring index");
    a_busy_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> r_v1 && r_v2 && r_v3)
        else $error("busy with an empty stage");
`endif

endmodule
`default_nettype wire

### rtl/vrcp_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vrcp_emit: point emitter
// Holds one cell's slot set and sends one point per cycle, lowest slot
// first, then the closing repeat point; results leave through a register.
// ----------------------------------------------------------------------------
module vrcp_emit
    import vrcp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_cell i_cell,
    output logic       o_ready,
    output logic       o_strobe,
    output t_out       o_result
);

    t_cell           r_cell;
    logic [RING-1:0] r_mask;
    logic            r_rep;
    logic            r_strobe;
    t_out            r_result;

    logic [RING-1:0] mask_after;
    logic [RING-1:0] onehot;
    logic [2:0]      sel;
    logic            active;
    logic            remain;
    logic            n_strobe;
    t_out            n_result;

    assign mask_after = r_mask & (r_mask - 8'd1);
    assign onehot     = r_mask & ~(r_mask - 8'd1);
    assign active     = (|r_mask) || r_rep;
    assign remain     = (|r_mask) ? ((|mask_after) || r_rep) : 1'b0;
    assign o_ready    = !remain;

    always_comb begin
        sel = 3'd0;
        for (int j = 0; j < RING; j++) begin
            if (onehot[j]) begin
                sel = 3'(j);
            end
        end
    end

    always_comb begin
        n_strobe = active;
        if (|r_mask) begin
            n_result.ring_index   = r_cell.ridx[sel];
            n_result.line_number  = r_cell.lab[sel];
            n_result.last_in_line = r_cell.lst[sel];
            n_result.last_of_cell = !(|mask_after) && !r_rep;
        end else begin
            n_result.ring_index   = r_cell.rep_idx;
            n_result.line_number  = 2'd0;
            n_result.last_in_line = 1'b1;
            n_result.last_of_cell = 1'b1;
        end
        n_result.point_x = coord_x(n_result.ring_index);
        n_result.point_y = coord_y(n_result.ring_index);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_rep    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
            if (i_load) begin
                r_mask <= i_cell.mask;
                r_rep  <= i_cell.rep;
            end else if (|r_mask) begin
                r_mask <= mask_after;
            end else begin
                r_rep <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cell <= i_cell;
        end
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire
